// ----- design/fixed_block_pool_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define FBPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, command and status codes, transfer types, sequencer states.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W          = 32;
    localparam int SIZE_W          = 16;
    localparam int CNT_W           = 9;
    localparam int FAIL_W          = 32;
    localparam int SPAN_W          = CNT_W + SIZE_W;
    localparam int MOD_CNT_W       = $clog2(SPAN_W);
    localparam int CFG_IDX_W       = 2;
    localparam int POOL_DEPTH_DEF  = 256;
    localparam int RST_SIZE        = 16;
    localparam int RST_COUNT       = 256;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_VALIDATE = 2'd2,
        CMD_REINIT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_NOT_IN_POOL = 2'd2,
        ST_DROPPED     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_address;
        logic              is_valid;
        logic [CNT_W-1:0]  allocated_count;
        logic [CNT_W-1:0]  available_count;
        logic [FAIL_W-1:0] failure_count;
    } t_out_item;

endpackage

// ----- design/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free-address stack in one memory, run by a small sequencer.
// ----------------------------------------------------------------------------
// Commands enter on i_in (valid/stall) and each gives one result on o_out
// (valid/stall). Configuration registers are written on the i_cfg channel,
// which is always ready; write them only while the block is idle.
// One command is worked on at a time; o_in_stall is high while busy.
// Each command passes through the sequencer states in order: allocate
// goes S_EXEC, S_READ (registered read data from the stack memory) and
// S_DONE, or straight to S_DONE when refused; deallocate goes S_EXEC,
// S_DONE; validate of an address inside the pool adds S_MOD (one remainder
// bit per cycle in the subtract-compare unit); reinitialize adds S_FILL (one
// stack entry written per cycle). A new command is accepted from the
// cycle in which the previous result turns valid.
// After reset the stack is filled with min(256, POOL_DEPTH) entries; no
// command is taken meanwhile. A finished result sits in an output register;
// the next command is accepted while it waits. If the receiver stalls, the
// result holds and a later result waits in the sequencer.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  fbpa_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output fbpa_pkg::t_out_item                   o_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]           i_cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int RST_FILL  = (POOL_DEPTH < RST_COUNT) ? POOL_DEPTH : RST_COUNT;

    logic [ADDR_W-1:0]    r_cfg_base;
    logic [SIZE_W-1:0]    r_cfg_size;
    logic [CNT_W-1:0]     r_cfg_count;

    logic [ADDR_W-1:0]    mem [POOL_DEPTH];
    logic [ADDR_W-1:0]    r_rd_data;

    t_state               r_state,     n_state;
    t_in_item             r_item,      n_item;
    logic [ADDR_W:0]      r_off,       n_off;
    logic [SPAN_W-1:0]    r_span,      n_span;
    logic [CNT_W-1:0]     r_top,       n_top;
    logic [CNT_W-1:0]     r_in_use,    n_in_use;
    logic [FAIL_W-1:0]    r_refusals,  n_refusals;
    logic [ADDR_W-1:0]    r_fill_addr, n_fill_addr;
    logic [SIZE_W-1:0]    r_fill_step, n_fill_step;
    logic [CNT_W-1:0]     r_fill_idx,  n_fill_idx;
    logic [CNT_W-1:0]     r_fill_last, n_fill_last;
    logic                 r_fill_reply, n_fill_reply;
    logic [SIZE_W-1:0]    r_rem,       n_rem;
    logic [SIZE_W-1:0]    r_div,       n_div;
    logic [MOD_CNT_W-1:0] r_mod_cnt,   n_mod_cnt;
    t_status              r_res_status, n_res_status;
    logic [ADDR_W-1:0]    r_res_blk,   n_res_blk;
    logic                 r_res_valid, n_res_valid;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out,       n_out;

    logic [SIZE_W-1:0]    w_eff_size;
    logic [CNT_W-1:0]     w_eff_count;
    logic                 w_in_range;
    logic                 w_fill_end;
    logic [SPAN_W-1:0]    w_dividend;
    logic [SIZE_W:0]      w_trial;
    logic [SIZE_W-1:0]    w_rem_next;
    logic                 w_we;
    logic [IDX_W-1:0]     w_widx;
    logic [ADDR_W-1:0]    w_wdata;
    logic [IDX_W-1:0]     w_ridx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_size  <= SIZE_W'(RST_SIZE);
            r_cfg_count <= CNT_W'(RST_COUNT);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:  r_cfg_base  <= i_cfg_data;
                CFG_SIZE:  r_cfg_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_COUNT: r_cfg_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff_size = (r_cfg_size == '0) ? SIZE_W'(1) : r_cfg_size;
        if (r_cfg_count == '0) begin
            w_eff_count = CNT_W'(1);
        end else if (int'(r_cfg_count) > POOL_DEPTH) begin
            w_eff_count = CNT_W'(POOL_DEPTH);
        end else begin
            w_eff_count = r_cfg_count;
        end
    end

    assign w_in_range = !r_off[ADDR_W] && (r_off[ADDR_W-1:0] < ADDR_W'(r_span));
    assign w_fill_end = (r_fill_idx == (r_fill_last - CNT_W'(1)));
    assign w_dividend = r_off[SPAN_W-1:0];
    assign w_trial    = {r_rem, w_dividend[r_mod_cnt]};
    assign w_rem_next = (w_trial >= {1'b0, r_div}) ? SIZE_W'(w_trial - {1'b0, r_div})
                                                   : w_trial[SIZE_W-1:0];
    assign w_ridx     = IDX_W'(r_top - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_off        = r_off;
        n_span       = r_span;
        n_top        = r_top;
        n_in_use     = r_in_use;
        n_refusals   = r_refusals;
        n_fill_addr  = r_fill_addr;
        n_fill_step  = r_fill_step;
        n_fill_idx   = r_fill_idx;
        n_fill_last  = r_fill_last;
        n_fill_reply = r_fill_reply;
        n_rem        = r_rem;
        n_div        = r_div;
        n_mod_cnt    = r_mod_cnt;
        n_res_status = r_res_status;
        n_res_blk    = r_res_blk;
        n_res_valid  = r_res_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        w_we         = 1'b0;
        w_widx       = IDX_W'(r_fill_idx);
        w_wdata      = r_fill_addr;

        unique case (r_state)
            S_FILL: begin
                w_we        = 1'b1;
                n_fill_addr = r_fill_addr + ADDR_W'(r_fill_step);
                n_fill_idx  = r_fill_idx + CNT_W'(1);
                if (w_fill_end) begin
                    n_state = r_fill_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_span  = SPAN_W'(w_eff_count) * SPAN_W'(w_eff_size);
                    n_off   = {1'b0, i_in.address} - {1'b0, r_cfg_base};
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_blk    = '0;
                n_res_valid  = 1'b0;
                n_state      = S_DONE;
                unique case (r_item.cmd)
                    CMD_ALLOC: begin
                        priority if (r_item.request_size != w_eff_size) begin
                            n_res_status = ST_NOT_IN_POOL;
                        end else if (r_top == '0) begin
                            n_res_status = ST_EXHAUSTED;
                            if (r_refusals != '1) begin
                                n_refusals = r_refusals + FAIL_W'(1);
                            end
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    CMD_FREE: begin
                        priority if (!w_in_range) begin
                            n_res_status = ST_NOT_IN_POOL;
                        end else if (r_top < w_eff_count) begin
                            w_we    = 1'b1;
                            w_widx  = IDX_W'(r_top);
                            w_wdata = r_item.address;
                            n_top   = r_top + CNT_W'(1);
                            if (r_in_use != '0) begin
                                n_in_use = r_in_use - CNT_W'(1);
                            end
                        end else begin
                            n_res_status = ST_DROPPED;
                        end
                    end
                    CMD_VALIDATE: begin
                        if (w_in_range) begin
                            n_rem     = '0;
                            n_div     = w_eff_size;
                            n_mod_cnt = MOD_CNT_W'(SPAN_W - 1);
                            n_state   = S_MOD;
                        end
                    end
                    CMD_REINIT: begin
                        n_fill_addr  = r_cfg_base;
                        n_fill_step  = w_eff_size;
                        n_fill_idx   = '0;
                        n_fill_last  = w_eff_count;
                        n_fill_reply = 1'b1;
                        n_top        = w_eff_count;
                        n_in_use     = '0;
                        n_refusals   = '0;
                        n_state      = S_FILL;
                    end
                    default: ;
                endcase
            end
            S_READ: begin
                n_res_blk = r_rd_data;
                n_top     = r_top - CNT_W'(1);
                if (r_in_use != '1) begin
                    n_in_use = r_in_use + CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_MOD: begin
                n_rem     = w_rem_next;
                n_mod_cnt = r_mod_cnt - MOD_CNT_W'(1);
                if (r_mod_cnt == '0) begin
                    n_res_valid = (w_rem_next == '0);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_res_status;
                    n_out.block_address   = r_res_blk;
                    n_out.is_valid        = r_res_valid;
                    n_out.allocated_count = r_in_use;
                    n_out.available_count = r_top;
                    n_out.failure_count   = r_refusals;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_top        <= CNT_W'(RST_FILL);
            r_in_use     <= '0;
            r_refusals   <= '0;
            r_fill_addr  <= '0;
            r_fill_step  <= SIZE_W'(RST_SIZE);
            r_fill_idx   <= '0;
            r_fill_last  <= CNT_W'(RST_FILL);
            r_fill_reply <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_top        <= n_top;
            r_in_use     <= n_in_use;
            r_refusals   <= n_refusals;
            r_fill_addr  <= n_fill_addr;
            r_fill_step  <= n_fill_step;
            r_fill_idx   <= n_fill_idx;
            r_fill_last  <= n_fill_last;
            r_fill_reply <= n_fill_reply;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_off        <= n_off;
        r_span       <= n_span;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_mod_cnt    <= n_mod_cnt;
        r_res_status <= n_res_status;
        r_res_blk    <= n_res_blk;
        r_res_valid  <= n_res_valid;
        r_out        <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_widx] <= w_wdata;
        end
        r_rd_data <= mem[w_ridx];
    end

    `FBPA_ASSERT_SAME(a_top_bound, 1'b1, int'(r_top) <= POOL_DEPTH,
        "free stack top beyond pool depth")
    `FBPA_ASSERT_SAME(a_pop_nonempty, r_state == S_READ, r_top != '0,
        "pop from empty free stack")
    `FBPA_ASSERT_NEXT(a_fill_top, (r_state == S_FILL) && w_fill_end, r_top == r_fill_last,
        "stack top differs from fill length after refill")
    `FBPA_ASSERT_SAME(a_rem_below, r_state == S_MOD, r_rem < r_div,
        "partial remainder not below object size")

endmodule

// ----- dv/fixed_block_pool_allocator_test.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate, free, validate and reinit commands through the valid/stall
// channels and checks every result against a behavioral pool model or a listed
// expected result. A short stimulus table covers the extremes, then random
// phases each load a new pool setting and run mostly well-formed command
// streams with random gaps and stalls.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int unsigned RUN_ITEMS   = 1850;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE      = 300;
    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    localparam int unsigned SHOWN_MAX   = 10;
    localparam int unsigned CNT_SAT     = 511;

    typedef struct packed {
        t_cfg_idx          idx;
        logic [ADDR_W-1:0] val;
    } t_reg_write;

    typedef struct {
        bit         is_reg;
        t_reg_write w;
        t_in_item   item;
        bit         typed;
        t_out_item  want;
    } t_plan_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    t_cfg_idx             cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // pool model state
    logic [ADDR_W-1:0]    model_stack [POOL_DEPTH_DEF];
    int unsigned          free_top;
    int unsigned          blocks_out;
    logic [FAIL_W-1:0]    refused;
    logic [ADDR_W-1:0]    pool_base;
    logic [SIZE_W-1:0]    pool_obj_bytes;
    logic [CNT_W-1:0]     pool_count;

    t_out_item            pending_results [$];
    t_plan_row            plan [$];

    bit                   no_idle;
    bit                   hold_go;
    bit                   hold_on;
    int unsigned          cycle_count;
    int unsigned          mismatches;
    int unsigned          unexpected;
    int unsigned          settings_used;
    int unsigned          cmd_sent [4];
    int unsigned          status_seen [4];

    fixed_block_pool_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned blk_size();
        return (pool_obj_bytes == 0) ? 1 : int'(pool_obj_bytes);
    endfunction

    function automatic int unsigned blk_count();
        if (pool_count == 0)
            return 1;
        if (pool_count > POOL_DEPTH_DEF)
            return POOL_DEPTH_DEF;
        return int'(pool_count);
    endfunction

    task automatic refill_pool();
        int unsigned n;
        int unsigned sz;
        n  = blk_count();
        sz = blk_size();
        for (int unsigned i = 0; i < POOL_DEPTH_DEF; i++) begin
            model_stack[i] = (i < n) ? pool_base + i * sz : '0;
        end
        free_top   = n;
        blocks_out = 0;
        refused    = '0;
    endtask

    task automatic pool_reset();
        pool_base      = '0;
        pool_obj_bytes = SIZE_W'(RST_SIZE);
        pool_count     = CNT_W'(RST_COUNT);
        refill_pool();
    endtask

    task automatic pool_write_reg(input t_reg_write w);
        case (w.idx)
            CFG_BASE:  pool_base      = w.val;
            CFG_SIZE:  pool_obj_bytes = w.val[SIZE_W-1:0];
            CFG_COUNT: pool_count     = w.val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic pool_model_step(input t_in_item it, output t_out_item r);
        logic [63:0] off;
        bit          hit;
        r   = '0;
        off = {32'h0, it.address} - {32'h0, pool_base};
        hit = (it.address >= pool_base) && (off < 64'(blk_count() * blk_size()));
        case (it.cmd)
            CMD_ALLOC: begin
                if (it.request_size != blk_size()) begin
                    r.status = ST_NOT_IN_POOL;
                end else if (free_top == 0) begin
                    r.status = ST_EXHAUSTED;
                    if (refused != '1)
                        refused++;
                end else begin
                    free_top--;
                    r.block_address = model_stack[free_top];
                    if (blocks_out < CNT_SAT)
                        blocks_out++;
                end
            end
            CMD_FREE: begin
                if (!hit) begin
                    r.status = ST_NOT_IN_POOL;
                end else if (free_top < blk_count()) begin
                    model_stack[free_top] = it.address;
                    free_top++;
                    if (blocks_out > 0)
                        blocks_out--;
                end else begin
                    r.status = ST_DROPPED;
                end
            end
            CMD_VALIDATE: r.is_valid = hit && ((off % blk_size()) == 0);
            CMD_REINIT:   refill_pool();
            default: ;
        endcase
        r.allocated_count = CNT_W'(blocks_out);
        r.available_count = CNT_W'(free_top);
        r.failure_count   = refused;
    endtask

    function automatic t_in_item mk(t_cmd c, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
        t_in_item it;
        it.cmd          = c;
        it.request_size = sz;
        it.address      = a;
        return it;
    endfunction

    function automatic t_out_item res(t_status st, logic [ADDR_W-1:0] blk, logic v,
                                      int unsigned used, int unsigned avail,
                                      logic [FAIL_W-1:0] fails);
        t_out_item r;
        r.status          = st;
        r.block_address   = blk;
        r.is_valid        = v;
        r.allocated_count = CNT_W'(used);
        r.available_count = CNT_W'(avail);
        r.failure_count   = fails;
        return r;
    endfunction

    function automatic t_reg_write wr(t_cfg_idx idx, logic [ADDR_W-1:0] val);
        t_reg_write w;
        w.idx = idx;
        w.val = val;
        return w;
    endfunction

    task automatic add_reg(input t_cfg_idx idx, input logic [ADDR_W-1:0] val);
        t_plan_row row;
        row.is_reg = 1'b1;
        row.w      = wr(idx, val);
        row.item   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endtask

    task automatic add_cmd(input t_in_item it, input bit typed, input t_out_item want);
        t_plan_row row;
        row.is_reg = 1'b0;
        row.w      = '0;
        row.item   = it;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endtask

    function automatic t_in_item draw_command();
        t_in_item    it;
        int unsigned roll;
        int unsigned k;
        int unsigned sz;
        int unsigned cnt;
        sz              = blk_size();
        cnt             = blk_count();
        roll            = $urandom_range(0, 99);
        k               = $urandom_range(0, cnt - 1);
        it.cmd          = t_cmd'($urandom_range(0, 3));
        it.request_size = SIZE_W'($urandom);
        it.address      = $urandom;
        if (roll < 12)
            return it;
        if (roll < 50) begin
            it.cmd          = CMD_ALLOC;
            it.request_size = ($urandom_range(0, 15) == 0) ? SIZE_W'(sz + 1) : SIZE_W'(sz);
        end else if (roll < 78) begin
            it.cmd     = CMD_FREE;
            it.address = pool_base + k * sz;
            case ($urandom_range(0, 9))
                0: it.address = pool_base + cnt * sz;
                1: it.address = it.address + $urandom_range(0, sz - 1);
                default: ;
            endcase
        end else if (roll < 97) begin
            it.cmd     = CMD_VALIDATE;
            it.address = pool_base + k * sz;
            case ($urandom_range(0, 5))
                0: it.address = pool_base + cnt * sz;
                1: it.address = pool_base - 1;
                2: it.address = it.address + $urandom_range(0, sz - 1);
                default: ;
            endcase
        end else begin
            it.cmd = CMD_REINIT;
        end
        return it;
    endfunction

    task automatic push_item(input t_in_item it, input bit typed, input t_out_item want);
        int unsigned gap;
        t_out_item   predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        pool_model_step(it, predicted);
        pending_results.push_back(typed ? want : predicted);
        cmd_sent[it.cmd]++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic load_regs(input t_reg_write w [$]);
        foreach (w[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= w[i].idx;
            cfg_data  <= w[i].val;
            do @(posedge clk); while (!cfg_ready);
            pool_write_reg(w[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_setting(output logic [ADDR_W-1:0] b, output logic [SIZE_W-1:0] s,
                                output logic [CNT_W-1:0] c);
        if ($urandom_range(0, 5) == 0) begin
            b = $urandom_range(0, 1) ? '0 : 32'hFFFF_FFFF - $urandom_range(0, 255);
            case ($urandom_range(0, 2))
                0: s = '0;
                1: s = 16'd1;
                default: s = 16'hFFFF;
            endcase
            case ($urandom_range(0, 3))
                0: c = '0;
                1: c = 9'd1;
                2: c = 9'd256;
                default: c = 9'd511;
            endcase
        end else begin
            b = $urandom_range(0, 1) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 4095) << 4);
            s = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(1, 64));
            c = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(1, 256))
                                            : CNT_W'($urandom_range(1, 12));
        end
    endtask

    task automatic take_result(input t_out_item got);
        t_out_item want;
        status_seen[got.status]++;
        if (pending_results.size() == 0) begin
            unexpected++;
            if (unexpected + mismatches <= SHOWN_MAX)
                $display("Result with nothing pending: %h", got);
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.block_address !== want.block_address ||
                got.is_valid !== want.is_valid ||
                got.allocated_count !== want.allocated_count ||
                got.available_count !== want.available_count ||
                got.failure_count !== want.failure_count) begin
                mismatches++;
                if (unexpected + mismatches <= SHOWN_MAX) begin
                    $display("Mismatch (expected/actual): status %0d/%0d block %h/%h valid %b/%b",
                             want.status, got.status, want.block_address, got.block_address,
                             want.is_valid, got.is_valid);
                    $display("  allocated %0d/%0d available %0d/%0d failures %0d/%0d",
                             want.allocated_count, got.allocated_count,
                             want.available_count, got.available_count,
                             want.failure_count, got.failure_count);
                end
            end
        end
    endtask

    initial begin : result_sink
        int unsigned pause;
        pause = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                take_result(out_item);
                pause = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_on) begin
                out_stall <= 1'b1;
            end else if (pause > 0) begin
                out_stall <= 1'b1;
                pause--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : long_hold
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial begin : stimulus
        t_reg_write        regs [$];
        int unsigned       row;
        int unsigned       sent;
        int unsigned       phase;
        int unsigned       phase_len;
        logic [ADDR_W-1:0] b;
        logic [SIZE_W-1:0] s;
        logic [CNT_W-1:0]  c;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BASE;
        cfg_data  <= '0;
        pool_reset();

        // after reset: base 0, 16-byte blocks, 256 blocks on the stack
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h0), 1, res(ST_OK, 0, 1, 0, 256, 0));
        add_cmd(mk(CMD_VALIDATE, 16'hFFFF, 32'hFFFF_FFFF), 1, res(ST_OK, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_ALLOC, 16'd16, 32'hFFFF_FFFF), 1, res(ST_OK, 32'h0FF0, 0, 1, 255, 0));
        add_cmd(mk(CMD_ALLOC, 16'h0, 32'h0), 1, res(ST_NOT_IN_POOL, 0, 0, 1, 255, 0));
        add_cmd(mk(CMD_ALLOC, 16'hFFFF, 32'h0), 1, res(ST_NOT_IN_POOL, 0, 0, 1, 255, 0));
        add_cmd(mk(CMD_FREE, 16'h0, 32'hFFFF_FFFF), 1, res(ST_NOT_IN_POOL, 0, 0, 1, 255, 0));
        add_cmd(mk(CMD_FREE, 16'h0, 32'h0FF0), 1, res(ST_OK, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_FREE, 16'h0, 32'h0), 1, res(ST_DROPPED, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h8), 1, res(ST_OK, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h1000), 1, res(ST_OK, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h0FF0), 1, res(ST_OK, 0, 1, 0, 256, 0));
        add_cmd(mk(CMD_REINIT, 16'hFFFF, 32'hFFFF_FFFF), 1, res(ST_OK, 0, 0, 0, 256, 0));
        // two blocks just below the top of the address space
        add_reg(CFG_COUNT, 32'd2);
        add_reg(CFG_BASE, 32'hFFFF_FF00);
        add_reg(CFG_SIZE, 32'h80);
        add_cmd(mk(CMD_REINIT, 16'h0, 32'h0), 1, res(ST_OK, 0, 0, 0, 2, 0));
        add_cmd(mk(CMD_ALLOC, 16'h80, 32'h0), 1, res(ST_OK, 32'hFFFF_FF80, 0, 1, 1, 0));
        add_cmd(mk(CMD_ALLOC, 16'h80, 32'h0), 1, res(ST_OK, 32'hFFFF_FF00, 0, 2, 0, 0));
        add_cmd(mk(CMD_ALLOC, 16'h80, 32'h0), 1, res(ST_EXHAUSTED, 0, 0, 2, 0, 1));
        add_cmd(mk(CMD_FREE, 16'h0, 32'hFFFF_FF7F), 0, '0);
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'hFFFF_FF80), 0, '0);
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h0), 0, '0);
        add_cmd(mk(CMD_FREE, 16'h0, 32'hFFFF_FFFF), 0, '0);
        // zero size and zero count act as one, stack kept until reinit
        add_reg(CFG_SIZE, 32'h0);
        add_reg(CFG_COUNT, 32'h0);
        add_cmd(mk(CMD_ALLOC, 16'h0, 32'h0), 0, '0);
        add_cmd(mk(CMD_FREE, 16'h0, 32'hFFFF_FF00), 0, '0);
        add_cmd(mk(CMD_REINIT, 16'h0, 32'h0), 1, res(ST_OK, 0, 0, 0, 1, 0));
        add_cmd(mk(CMD_ALLOC, 16'h1, 32'h0), 1, res(ST_OK, 32'hFFFF_FF00, 0, 1, 0, 0));
        // count above the depth clamps, largest block size
        add_reg(CFG_BASE, 32'h0);
        add_reg(CFG_SIZE, 32'hFFFF);
        add_reg(CFG_COUNT, 32'd300);
        add_cmd(mk(CMD_REINIT, 16'h0, 32'h0), 1, res(ST_OK, 0, 0, 0, 256, 0));
        add_cmd(mk(CMD_ALLOC, 16'hFFFF, 32'h0), 0, '0);
        add_cmd(mk(CMD_VALIDATE, 16'h0, 32'h00FE_FF01), 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        row = 0;
        while (row < plan.size()) begin
            if (plan[row].is_reg) begin
                regs.delete();
                while (row < plan.size() && plan[row].is_reg) begin
                    regs.push_back(plan[row].w);
                    row++;
                end
                drain();
                load_regs(regs);
                settings_used++;
            end else begin
                push_item(plan[row].item, plan[row].typed, plan[row].want);
                row++;
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RUN_ITEMS) begin
            drain();
            pick_setting(b, s, c);
            regs.delete();
            regs.push_back(wr(CFG_BASE, b));
            regs.push_back(wr(CFG_SIZE, ADDR_W'(s)));
            regs.push_back(wr(CFG_COUNT, ADDR_W'(c)));
            load_regs(regs);
            settings_used++;
            no_idle <= ($urandom_range(0, 4) == 0);
            if (phase == 2)
                hold_go <= 1'b1;
            if ($urandom_range(0, 7) != 0) begin
                push_item(mk(CMD_REINIT, SIZE_W'($urandom), $urandom), 1'b0, '0);
                sent++;
            end
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                push_item(draw_command(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d allocate, %0d free, %0d validate, %0d reinit over %0d pool settings",
                 cmd_sent[CMD_ALLOC], cmd_sent[CMD_FREE], cmd_sent[CMD_VALIDATE],
                 cmd_sent[CMD_REINIT], settings_used);
        $display("Saw %0d ok, %0d exhausted, %0d not in pool, %0d dropped; %0d bad, %0d stray",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NOT_IN_POOL],
                 status_seen[ST_DROPPED], mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
